// ----- hdl/rbp_pkg.sv -----
// Shared types, phase codes and field tables for the record body byte parser.
`timescale 1ns / 1ps

package rbp_pkg;

	localparam int TAG_W = 5;

	localparam logic [TAG_W-1:0] PH_ID         = 5'd0;
	localparam logic [TAG_W-1:0] PH_LAYER      = 5'd1;
	localparam logic [TAG_W-1:0] PH_PCLASS     = 5'd2;
	localparam logic [TAG_W-1:0] PH_CLOCK      = 5'd3;
	localparam logic [TAG_W-1:0] PH_RESERVED   = 5'd4;
	localparam logic [TAG_W-1:0] PH_TS         = 5'd5;
	localparam logic [TAG_W-1:0] PH_VER        = 5'd6;
	localparam logic [TAG_W-1:0] PH_HASH       = 5'd7;
	localparam logic [TAG_W-1:0] PH_PATH_LEN   = 5'd8;
	localparam logic [TAG_W-1:0] PH_PATH       = 5'd9;
	localparam logic [TAG_W-1:0] PH_TYPE_LEN   = 5'd10;
	localparam logic [TAG_W-1:0] PH_TYPE       = 5'd11;
	localparam logic [TAG_W-1:0] PH_KIND_LEN   = 5'd12;
	localparam logic [TAG_W-1:0] PH_KIND       = 5'd13;
	localparam logic [TAG_W-1:0] PH_META_CNT   = 5'd14;
	localparam logic [TAG_W-1:0] PH_KEY_LEN    = 5'd15;
	localparam logic [TAG_W-1:0] PH_KEY        = 5'd16;
	localparam logic [TAG_W-1:0] PH_VAL_LEN    = 5'd17;
	localparam logic [TAG_W-1:0] PH_VAL        = 5'd18;
	localparam logic [TAG_W-1:0] PH_LINK_CNT   = 5'd19;
	localparam logic [TAG_W-1:0] PH_LINK_TGT   = 5'd20;
	localparam logic [TAG_W-1:0] PH_REL_LEN    = 5'd21;
	localparam logic [TAG_W-1:0] PH_REL        = 5'd22;
	localparam logic [TAG_W-1:0] PH_PAYLOAD_LEN = 5'd23;
	localparam logic [TAG_W-1:0] PH_PAYLOAD    = 5'd24;
	localparam logic [TAG_W-1:0] PH_TRAIL      = 5'd25;

	localparam logic [1:0] ST_PARSING  = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_CORRUPT  = 2'd2;

	// Length of each field whose size is fixed by the layout; string bodies
	// take their length from the preceding length field instead.
	function automatic logic [31:0] fixed_len(input logic [TAG_W-1:0] ph);
		logic [31:0] len;
		case (ph)
			PH_ID:          len = 32'd16;
			PH_LAYER:       len = 32'd1;
			PH_PCLASS:      len = 32'd1;
			PH_CLOCK:       len = 32'd1;
			PH_RESERVED:    len = 32'd1;
			PH_TS:          len = 32'd8;
			PH_VER:         len = 32'd4;
			PH_HASH:        len = 32'd32;
			PH_PATH_LEN:    len = 32'd2;
			PH_TYPE_LEN:    len = 32'd2;
			PH_KIND_LEN:    len = 32'd2;
			PH_META_CNT:    len = 32'd2;
			PH_KEY_LEN:     len = 32'd2;
			PH_VAL_LEN:     len = 32'd2;
			PH_LINK_CNT:    len = 32'd2;
			PH_LINK_TGT:    len = 32'd16;
			PH_REL_LEN:     len = 32'd2;
			PH_PAYLOAD_LEN: len = 32'd4;
			default:        len = 32'd0;
		endcase
		return len;
	endfunction

	// Fields whose bytes form a little-endian number.
	function automatic logic is_numeric(input logic [TAG_W-1:0] ph);
		logic num;
		case (ph)
			PH_LAYER, PH_PCLASS, PH_CLOCK, PH_RESERVED, PH_TS, PH_VER,
			PH_PATH_LEN, PH_TYPE_LEN, PH_KIND_LEN, PH_META_CNT, PH_KEY_LEN,
			PH_VAL_LEN, PH_LINK_CNT, PH_REL_LEN, PH_PAYLOAD_LEN: num = 1'b1;
			default: num = 1'b0;
		endcase
		return num;
	endfunction

	typedef struct packed {
		logic [TAG_W-1:0] field_tag;
		logic [7:0]       byte_value;
		logic [31:0]      offset_in_field;
		logic [15:0]      entry_index;
		logic             field_end;
		logic [63:0]      field_value;
		logic [1:0]       parse_status;
	} rbp_result_t;

endpackage

// ----- hdl/rbp_step.sv -----
// Parse state registers and the per-byte next-state and tagging logic.
`timescale 1ns / 1ps

module rbp_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                is_last,
	output rbp_pkg::rbp_result_t res
);

	logic [rbp_pkg::TAG_W-1:0] phase_q, phase_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] length_q, length_d;
	logic [63:0] acc_q, acc_d;
	logic [15:0] meta_rem_q, meta_rem_d;
	logic [15:0] link_rem_q, link_rem_d;
	logic [15:0] list_idx_q, list_idx_d;

	logic [63:0] acc_upd;
	logic [31:0] off_inc;
	logic [31:0] n;
	logic [15:0] meta_dec;
	logic [15:0] link_dec;
	logic        numeric;
	logic        done;
	logic        go;
	logic        use_n;
	logic [rbp_pkg::TAG_W-1:0] nph;

	always_comb begin
		numeric  = rbp_pkg::is_numeric(phase_q);
		off_inc  = offset_q + 32'd1;
		acc_upd  = acc_q;
		if (numeric && offset_q < 32'd8) begin
			acc_upd = acc_q | ({56'd0, data_byte} << {offset_q[2:0], 3'b000});
		end
		n        = acc_upd[31:0];
		meta_dec = meta_rem_q - 16'd1;
		link_dec = link_rem_q - 16'd1;
		done     = (phase_q != rbp_pkg::PH_TRAIL) && (off_inc >= length_q);

		phase_d    = phase_q;
		offset_d   = offset_q;
		length_d   = length_q;
		acc_d      = acc_q;
		meta_rem_d = meta_rem_q;
		link_rem_d = link_rem_q;
		list_idx_d = list_idx_q;
		go         = 1'b0;
		use_n      = 1'b0;
		nph        = phase_q;

		if (phase_q == rbp_pkg::PH_TRAIL) begin
			if (offset_q != 32'hFFFF_FFFF) begin
				offset_d = off_inc;
			end
		end else begin
			offset_d = off_inc;
			acc_d    = acc_upd;
		end

		// Choose the next field when the current one completes. A zero length
		// or count skips straight to whatever follows it.
		if (done) begin
			go = 1'b1;
			case (phase_q)
				rbp_pkg::PH_PATH_LEN: begin
					use_n = (n != 32'd0);
					nph   = use_n ? rbp_pkg::PH_PATH : rbp_pkg::PH_TYPE_LEN;
				end
				rbp_pkg::PH_PATH: nph = rbp_pkg::PH_TYPE_LEN;
				rbp_pkg::PH_TYPE_LEN: begin
					use_n = (n != 32'd0);
					nph   = use_n ? rbp_pkg::PH_TYPE : rbp_pkg::PH_KIND_LEN;
				end
				rbp_pkg::PH_TYPE: nph = rbp_pkg::PH_KIND_LEN;
				rbp_pkg::PH_KIND_LEN: begin
					use_n = (n != 32'd0);
					nph   = use_n ? rbp_pkg::PH_KIND : rbp_pkg::PH_META_CNT;
				end
				rbp_pkg::PH_KIND: nph = rbp_pkg::PH_META_CNT;
				rbp_pkg::PH_META_CNT: begin
					meta_rem_d = n[15:0];
					list_idx_d = 16'd0;
					nph = (n[15:0] != 16'd0) ? rbp_pkg::PH_KEY_LEN : rbp_pkg::PH_LINK_CNT;
				end
				rbp_pkg::PH_KEY_LEN: begin
					use_n = (n != 32'd0);
					nph   = use_n ? rbp_pkg::PH_KEY : rbp_pkg::PH_VAL_LEN;
				end
				rbp_pkg::PH_KEY: nph = rbp_pkg::PH_VAL_LEN;
				rbp_pkg::PH_VAL_LEN, rbp_pkg::PH_VAL: begin
					if (phase_q == rbp_pkg::PH_VAL_LEN && n != 32'd0) begin
						use_n = 1'b1;
						nph   = rbp_pkg::PH_VAL;
					end else begin
						meta_rem_d = meta_dec;
						list_idx_d = list_idx_q + 16'd1;
						nph = (meta_dec != 16'd0) ? rbp_pkg::PH_KEY_LEN : rbp_pkg::PH_LINK_CNT;
					end
				end
				rbp_pkg::PH_LINK_CNT: begin
					link_rem_d = n[15:0];
					list_idx_d = 16'd0;
					nph = (n[15:0] != 16'd0) ? rbp_pkg::PH_LINK_TGT
					                         : rbp_pkg::PH_PAYLOAD_LEN;
				end
				rbp_pkg::PH_LINK_TGT: nph = rbp_pkg::PH_REL_LEN;
				rbp_pkg::PH_REL_LEN, rbp_pkg::PH_REL: begin
					if (phase_q == rbp_pkg::PH_REL_LEN && n != 32'd0) begin
						use_n = 1'b1;
						nph   = rbp_pkg::PH_REL;
					end else begin
						link_rem_d = link_dec;
						list_idx_d = list_idx_q + 16'd1;
						nph = (link_dec != 16'd0) ? rbp_pkg::PH_LINK_TGT
						                          : rbp_pkg::PH_PAYLOAD_LEN;
					end
				end
				rbp_pkg::PH_PAYLOAD_LEN: begin
					use_n = (n != 32'd0);
					nph   = use_n ? rbp_pkg::PH_PAYLOAD : rbp_pkg::PH_TRAIL;
				end
				rbp_pkg::PH_PAYLOAD: nph = rbp_pkg::PH_TRAIL;
				default: begin
					if (phase_q < rbp_pkg::PH_PATH_LEN) begin
						nph = phase_q + 5'd1;
					end else begin
						nph = rbp_pkg::PH_TRAIL;
					end
				end
			endcase
		end

		if (go) begin
			phase_d  = nph;
			length_d = use_n ? n : rbp_pkg::fixed_len(nph);
			offset_d = 32'd0;
			acc_d    = 64'd0;
		end

		res.field_tag       = phase_q;
		res.byte_value      = data_byte;
		res.offset_in_field = offset_q;
		res.entry_index     = ((phase_q >= rbp_pkg::PH_KEY_LEN && phase_q <= rbp_pkg::PH_VAL) ||
		                       (phase_q >= rbp_pkg::PH_LINK_TGT && phase_q <= rbp_pkg::PH_REL))
		                      ? list_idx_q : 16'd0;
		res.field_end       = done;
		res.field_value     = (done && numeric) ? acc_upd : 64'd0;
		if (phase_d == rbp_pkg::PH_TRAIL) begin
			res.parse_status = rbp_pkg::ST_COMPLETE;
		end else if (is_last) begin
			res.parse_status = rbp_pkg::ST_CORRUPT;
		end else begin
			res.parse_status = rbp_pkg::ST_PARSING;
		end

		// The final byte of a body puts the parser back at the start.
		if (is_last) begin
			phase_d    = rbp_pkg::PH_ID;
			offset_d   = 32'd0;
			length_d   = rbp_pkg::fixed_len(rbp_pkg::PH_ID);
			acc_d      = 64'd0;
			meta_rem_d = 16'd0;
			link_rem_d = 16'd0;
			list_idx_d = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rbp_pkg::PH_ID;
			offset_q   <= 32'd0;
			length_q   <= rbp_pkg::fixed_len(rbp_pkg::PH_ID);
			acc_q      <= 64'd0;
			meta_rem_q <= 16'd0;
			link_rem_q <= 16'd0;
			list_idx_q <= 16'd0;
		end else if (take) begin
			phase_q    <= phase_d;
			offset_q   <= offset_d;
			length_q   <= length_d;
			acc_q      <= acc_d;
			meta_rem_q <= meta_rem_d;
			link_rem_q <= link_rem_d;
			list_idx_q <= list_idx_d;
		end
	end

endmodule

// ----- hdl/rbp_out_reg.sv -----
// Result register with the output handshake and the input ready.
`timescale 1ns / 1ps

module rbp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rbp_pkg::rbp_result_t res_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rbp_pkg::rbp_result_t res_out
);

	logic                 valid_q;
	rbp_pkg::rbp_result_t res_q;

	// The register can load whenever it is empty or its request leaves now.
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= res_in;
		end
	end

endmodule

// ----- hdl/record_body_byte_parser.sv -----
// Top level of the record body byte parser.
`timescale 1ns / 1ps

// The record body byte parser takes a record body one byte per request on the
// slave stream (s_tdata holds the byte, s_tlast marks the final byte of the
// body) and returns one result request on the master stream for every byte.
// Each result names the field that the byte belongs to (m_tuser), the byte
// itself, its offset within the field, the meta pair or link index for list
// fields, whether the byte closes its field, the little-endian value of a
// numeric field at its last byte, and the parse status.
// The result is registered: a byte accepted at one edge shows its result from
// that edge on. Throughput is one byte per cycle; the only limit is the
// single result register, whose ready feeds back to s_tready.
// When m_tready is low the result register holds its request, and s_tready
// drops until it is taken, so no result is lost or repeated.
// Reset puts the parser at the start of the id field with all counters at
// zero and empties the result register. The byte carrying s_tlast also
// returns the parser to that start state, so the next byte opens a new body.
// A body that ends before its payload is complete reports status corrupt on
// its final byte; bytes after the payload are tagged trailing.

module record_body_byte_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // is_last
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] byte_value, [39:8] offset_in_field, [55:40] entry_index,
	// [56] field_end, [120:57] field_value, [122:121] parse_status, rest zero
	output logic [127:0] m_tdata,
	output logic [4:0]   m_tuser    // [4:0] field_tag
);

	rbp_pkg::rbp_result_t step_res;
	rbp_pkg::rbp_result_t out_res;
	logic                 take;

	assign take = s_tvalid && s_tready;

	rbp_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_tdata),
		.is_last   (s_tlast),
		.res       (step_res)
	);

	rbp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.res_in    (step_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_out   (out_res)
	);

	assign m_tuser = out_res.field_tag;
	assign m_tdata = {5'd0,
	                  out_res.parse_status,
	                  out_res.field_value,
	                  out_res.field_end,
	                  out_res.entry_index,
	                  out_res.offset_in_field,
	                  out_res.byte_value};

endmodule
